FILE: src/wsctf_pkg.sv
// Package for the WebSocket client text framer.
// Holds the item structs, the header constants and the masking key byte select.
// No dependencies.
package wsctf_pkg;

    localparam logic [7:0]  HDR_TEXT_FIN   = 8'h81;
    localparam logic [7:0]  HDR_MASK_BIT   = 8'h80;
    localparam logic [15:0] LEN_SHORT_MAX  = 16'd125;
    localparam logic [6:0]  LEN_EXT16_CODE = 7'd126;
    localparam logic [3:0]  HDR_LEN_SHORT  = 4'd6;
    localparam logic [3:0]  HDR_LEN_EXT16  = 4'd8;
    localparam logic [3:0]  KEY_OFS_SHORT  = 4'd2;
    localparam logic [3:0]  KEY_OFS_EXT16  = 4'd4;
    localparam logic [3:0]  SUB_MAX        = 4'd8;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first;
        logic [16:0] msg_length;
        logic [31:0] mask_key;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       rejected;
    } t_out_item;

    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = key[31:24];
            2'd1: b = key[23:16];
            2'd2: b = key[15:8];
            2'd3: b = key[7:0];
            default: b = key[31:24];
        endcase
        return b;
    endfunction

endpackage

FILE: src/websocket_client_text_framer_core.sv
// WebSocket client text framer: builds masked client text frames byte by byte.
// An accepted item waits in the input register; its results go to the output register.
// Throughput: one payload item per cycle unless the output stalls; a first item holds the input
// for its 6 to 9 frame results, or 1 when rejected; items with no result pass without output.
// Reset: synchronous active low; clears both registers' valid flags and the message state.
// Depends on wsctf_pkg.
module websocket_client_text_framer_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  wsctf_pkg::t_in_item   i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output wsctf_pkg::t_out_item  o_out_item,
    input  logic                  i_out_stall
);

    logic                 r_in_valid;
    wsctf_pkg::t_in_item  r_in;
    logic [3:0]           r_sub;
    logic [15:0]          r_pos;
    logic [15:0]          r_len;
    logic [31:0]          r_key;
    logic                 r_dropping;
    logic                 r_out_valid;
    wsctf_pkg::t_out_item r_out;

    logic [3:0]           n_sub;
    logic [15:0]          n_pos;
    logic [15:0]          n_len;
    logic [31:0]          n_key;
    logic                 n_dropping;

    logic                 out_free;
    logic                 len_ok;
    logic                 len_short;
    logic                 len_zero;
    logic [3:0]           hdr_len;
    logic [3:0]           n_res;
    logic [3:0]           key_ofs;
    logic [3:0]           key_sel;
    logic                 has_res;
    logic                 last_res;
    logic                 emit;
    logic                 consume;
    logic [15:0]          pos_inc;
    wsctf_pkg::t_out_item res;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign len_ok    = !r_in.msg_length[16];
    assign len_short = r_in.msg_length[15:0] <= wsctf_pkg::LEN_SHORT_MAX;
    assign len_zero  = r_in.msg_length[15:0] == 16'd0;
    assign hdr_len   = len_short ? wsctf_pkg::HDR_LEN_SHORT : wsctf_pkg::HDR_LEN_EXT16;
    assign key_ofs   = len_short ? wsctf_pkg::KEY_OFS_SHORT : wsctf_pkg::KEY_OFS_EXT16;
    assign key_sel   = r_sub - key_ofs;
    assign pos_inc   = r_pos + 16'd1;

    always_comb begin
        if (r_in.first) begin
            if (!len_ok) begin
                n_res = 4'd1;
            end else begin
                n_res = hdr_len + {3'd0, !len_zero};
            end
        end else begin
            n_res = (!r_dropping && (r_pos < r_len)) ? 4'd1 : 4'd0;
        end
    end

    assign has_res  = r_sub < n_res;
    assign last_res = (r_sub + 4'd1) >= n_res;
    assign emit     = r_in_valid && has_res && out_free;
    assign consume  = r_in_valid && (!has_res || (emit && last_res));
    assign o_in_stall = r_in_valid && !consume;

    always_comb begin
        res = '0;
        if (r_in.first) begin
            if (!len_ok) begin
                res.rejected = 1'b1;
            end else if (r_sub == 4'd0) begin
                res.out_byte = wsctf_pkg::HDR_TEXT_FIN;
            end else if (r_sub == 4'd1) begin
                res.out_byte = len_short ? (wsctf_pkg::HDR_MASK_BIT | r_in.msg_length[7:0])
                             : (wsctf_pkg::HDR_MASK_BIT | {1'b0, wsctf_pkg::LEN_EXT16_CODE});
            end else if (!len_short && r_sub == 4'd2) begin
                res.out_byte = r_in.msg_length[15:8];
            end else if (!len_short && r_sub == 4'd3) begin
                res.out_byte = r_in.msg_length[7:0];
            end else if (r_sub < hdr_len) begin
                res.out_byte  = wsctf_pkg::key_byte(r_in.mask_key, key_sel[1:0]);
                res.frame_end = len_zero && (key_sel[1:0] == 2'd3);
            end else begin
                res.out_byte  = r_in.payload_byte ^ r_in.mask_key[31:24];
                res.frame_end = r_in.msg_length[15:0] == 16'd1;
            end
        end else begin
            res.out_byte  = r_in.payload_byte ^ wsctf_pkg::key_byte(r_key, r_pos[1:0]);
            res.frame_end = pos_inc == r_len;
        end
    end

    always_comb begin
        n_sub      = r_sub;
        n_pos      = r_pos;
        n_len      = r_len;
        n_key      = r_key;
        n_dropping = r_dropping;
        if (consume) begin
            n_sub = 4'd0;
            if (r_in.first) begin
                if (!len_ok) begin
                    n_pos      = 16'd0;
                    n_len      = 16'd0;
                    n_dropping = 1'b1;
                end else begin
                    n_pos      = {15'd0, !len_zero};
                    n_len      = r_in.msg_length[15:0];
                    n_key      = r_in.mask_key;
                    n_dropping = 1'b0;
                end
            end else if (has_res) begin
                n_pos = pos_inc;
            end
        end else if (emit) begin
            n_sub = r_sub + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_sub       <= 4'd0;
            r_pos       <= 16'd0;
            r_len       <= 16'd0;
            r_key       <= 32'd0;
            r_dropping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_sub      <= n_sub;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_key      <= n_key;
            r_dropping <= n_dropping;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rejected) |-> (o_out_item.out_byte == 8'd0 &&
        !o_out_item.frame_end))
        else $error("rejected item carries data");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub <= wsctf_pkg::SUB_MAX)
        else $error("result index out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result overwritten");

endmodule

FILE: verif/websocket_client_text_framer_core_test.sv
// Self-checking testbench for websocket_client_text_framer_core: a directed table, then random
// messages under varied idling and back-pressure, checked item by item against a frame predictor.
// Depends on wsctf_pkg and the core RTL.
module websocket_client_text_framer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [16:0] MAX_FRAME_LEN = 17'd65535;
    localparam int          PRED          = -1;
    localparam int          N_DIR         = 23;
    localparam int          N_RANDOM      = 80;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          QUIET_LIMIT   = 3000;
    localparam int          DRAIN_CYCLES  = 20;

    localparam wsctf_pkg::t_out_item NO_ITEM     = '0;
    localparam wsctf_pkg::t_out_item REJECT_ITEM =
        '{out_byte: 8'h00, frame_end: 1'b0, rejected: 1'b1};

    typedef struct packed {
        wsctf_pkg::t_in_item  item;
        int                   n_typed;
        wsctf_pkg::t_out_item typed;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{'{8'hFF, 1'b0, 17'd0,      32'h0000_0000}, 0,    NO_ITEM},
        '{'{8'hAA, 1'b1, 17'd0,      32'hFFFF_FFFF}, PRED, NO_ITEM},
        '{'{8'h00, 1'b0, 17'd0,      32'h0000_0000}, 0,    NO_ITEM},
        '{'{8'hFF, 1'b1, 17'd1,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h5A, 1'b0, 17'd0,      32'h0000_0000}, 0,    NO_ITEM},
        '{'{8'h00, 1'b1, 17'd125,    32'h1234_5678}, PRED, NO_ITEM},
        '{'{8'hFF, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h55, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h3C, 1'b1, 17'd126,    32'hDEAD_BEEF}, PRED, NO_ITEM},
        '{'{8'h80, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h01, 1'b1, 17'd65535,  32'h8000_0001}, PRED, NO_ITEM},
        '{'{8'hFE, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h77, 1'b1, 17'd65536,  32'hCAFE_F00D}, 1,    REJECT_ITEM},
        '{'{8'h11, 1'b0, 17'd0,      32'h0000_0000}, 0,    NO_ITEM},
        '{'{8'hFF, 1'b1, 17'd131071, 32'hFFFF_FFFF}, 1,    REJECT_ITEM},
        '{'{8'h22, 1'b0, 17'h1FFFF,  32'hFFFF_FFFF}, 0,    NO_ITEM},
        '{'{8'hC3, 1'b1, 17'd4,      32'hA5A5_5A5A}, PRED, NO_ITEM},
        '{'{8'h3C, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h00, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'hFF, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM},
        '{'{8'h99, 1'b0, 17'd0,      32'h0000_0000}, 0,    NO_ITEM},
        '{'{8'h10, 1'b1, 17'd2,      32'h0102_0304}, PRED, NO_ITEM},
        '{'{8'h20, 1'b0, 17'd0,      32'h0000_0000}, PRED, NO_ITEM}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    wsctf_pkg::t_in_item  i_in_item   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    wsctf_pkg::t_out_item o_out_item;

    websocket_client_text_framer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // Frame predictor state
    logic [15:0]          msg_pos      = '0;
    logic [15:0]          msg_len      = '0;
    logic [31:0]          msg_key      = '0;
    logic                 msg_dropping = 1'b0;
    wsctf_pkg::t_out_item frame_out [9];

    wsctf_pkg::t_out_item wire_bytes_q [$];
    wsctf_pkg::t_out_item due;
    int          mismatches      = 0;
    int          fed_items       = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          hold_left       = 0;
    int          quiet_cycles    = 0;
    bit          hold_req        = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] idx);
        return key[8 * (3 - idx) +: 8];
    endfunction

    function automatic bit next_payload(input logic [7:0] data,
                                        output wsctf_pkg::t_out_item r);
        r = '0;
        if (msg_pos >= msg_len) begin
            return 1'b0;
        end
        r.out_byte  = data ^ mask_byte(msg_key, msg_pos[1:0]);
        msg_pos     = msg_pos + 16'd1;
        r.frame_end = (msg_pos == msg_len);
        return 1'b1;
    endfunction

    // Advance the predictor by one item; fill frame_out and return the result count.
    function automatic int build_frame_step(input wsctf_pkg::t_in_item it);
        int                   n;
        wsctf_pkg::t_out_item r;
        n = 0;
        foreach (frame_out[i]) frame_out[i] = '0;
        if (!it.first) begin
            if (!msg_dropping) begin
                if (next_payload(it.payload_byte, r)) begin
                    frame_out[0] = r;
                    n = 1;
                end
            end
            return n;
        end
        msg_pos = '0;
        if (it.msg_length > MAX_FRAME_LEN) begin
            msg_len      = '0;
            msg_dropping = 1'b1;
            frame_out[0] = REJECT_ITEM;
            return 1;
        end
        msg_dropping = 1'b0;
        msg_len      = it.msg_length[15:0];
        msg_key      = it.mask_key;
        frame_out[n].out_byte = wsctf_pkg::HDR_TEXT_FIN;
        n++;
        if (it.msg_length <= wsctf_pkg::LEN_SHORT_MAX) begin
            frame_out[n].out_byte = wsctf_pkg::HDR_MASK_BIT | it.msg_length[7:0];
            n++;
        end else begin
            frame_out[n].out_byte = wsctf_pkg::HDR_MASK_BIT | {1'b0, wsctf_pkg::LEN_EXT16_CODE};
            n++;
            frame_out[n].out_byte = it.msg_length[15:8];
            n++;
            frame_out[n].out_byte = it.msg_length[7:0];
            n++;
        end
        for (int i = 0; i < 4; i++) begin
            frame_out[n].out_byte  = mask_byte(it.mask_key, i[1:0]);
            frame_out[n].frame_end = (it.msg_length == 17'd0) && (i == 3);
            n++;
        end
        if (next_payload(it.payload_byte, r)) begin
            frame_out[n] = r;
            n++;
        end
        return n;
    endfunction

    // Offer one item, wait for it to be taken, then queue what it should produce.
    task automatic offer(input wsctf_pkg::t_in_item it, input int n_typed,
                         input wsctf_pkg::t_out_item typed);
        int n;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n = build_frame_step(it);
        if (n_typed >= 0) begin
            for (int i = 0; i < n_typed; i++) wire_bytes_q.push_back(typed);
        end else begin
            for (int i = 0; i < n; i++) wire_bytes_q.push_back(frame_out[i]);
        end
        fed_items++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                sender_idle_pct = 69;
                recv_stall_pct  = 0;
            end
            2: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 69;
            end
            3: begin
                sender_idle_pct = 14;
                recv_stall_pct  = 14;
            end
            default: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wire_bytes_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: byte %h end %b rej %b",
                             o_out_item.out_byte, o_out_item.frame_end, o_out_item.rejected);
                end
            end else begin
                due = wire_bytes_q.pop_front();
                if (o_out_item.out_byte !== due.out_byte ||
                    o_out_item.frame_end !== due.frame_end ||
                    o_out_item.rejected !== due.rejected) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: byte %h/%h end %b/%b rej %b/%b (expected/actual)",
                                 due.out_byte, o_out_item.out_byte,
                                 due.frame_end, o_out_item.frame_end,
                                 due.rejected, o_out_item.rejected);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        wsctf_pkg::t_in_item it;
        int                  pick;
        int                  extra;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        for (int r = 0; r < N_DIR; r++) begin
            offer(DIR_ROWS[r].item, DIR_ROWS[r].n_typed, DIR_ROWS[r].typed);
        end

        // hold the sender until every frame byte so far is out
        i_in_valid <= 1'b0;
        while (wire_bytes_q.size() != 0) @(posedge i_clk);

        fed_items = 0;
        hold_req  = 1'b1;
        while (fed_items < N_RANDOM) begin
            set_idling((fed_items / 20) % 4);
            pick            = int'($urandom_range(0, 99));
            it.first        = 1'b1;
            it.payload_byte = 8'($urandom);
            it.mask_key     = $urandom;
            if (pick < 60) begin
                it.msg_length = 17'($urandom_range(0, 8));
                extra = (it.msg_length == 0) ? 0 : int'(it.msg_length) - 1;
                if (pick >= 50) extra += int'($urandom_range(1, 2));
            end else if (pick < 78) begin
                it.msg_length = $urandom_range(0, 1) ? 17'($urandom_range(9, 125))
                                                     : 17'($urandom_range(126, 65535));
                extra = int'($urandom_range(0, 6));
            end else if (pick < 88) begin
                it.msg_length = 17'($urandom_range(65536, 131071));
                extra = int'($urandom_range(0, 3));
            end else begin
                it.first      = 1'($urandom);
                it.msg_length = 17'($urandom);
                extra = 0;
            end
            offer(it, PRED, NO_ITEM);
            repeat (extra) begin
                it.first        = 1'b0;
                it.payload_byte = 8'($urandom);
                it.msg_length   = 17'($urandom);
                it.mask_key     = $urandom;
                offer(it, PRED, NO_ITEM);
            end
        end

        i_in_valid <= 1'b0;
        while (wire_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && wire_bytes_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
src/wsctf_pkg.sv
src/websocket_client_text_framer_core.sv
verif/websocket_client_text_framer_core_test.sv
